### rtl/core/obst_pkg.sv
// ----------------------------------------------------------------------------
// obst_pkg: shared types and constants for the optimal BST builder
// Item and result beat structs, widths and the saturation constant.
// ----------------------------------------------------------------------------
package obst_pkg;

    localparam int unsigned CfgW  = 5;
    localparam int unsigned WgtW  = 22;
    localparam int unsigned CostW = 32;
    localparam logic [CostW-1:0] CostMax = '1;

    typedef struct packed {
        logic [15:0] miss_weight;
        logic [15:0] key_weight;
        logic [7:0]  key_label;
    } t_item;

    typedef struct packed {
        logic [4:0]  key_index;
        logic [7:0]  key_label_out;
        logic [4:0]  parent_index;
        logic        is_right_child;
        logic [3:0]  node_depth;
        logic [31:0] total_cost;
        logic        last;
    } t_result;

    // Saturating 32-bit add.
    function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                                 input logic [CostW-1:0] b);
        logic [CostW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CostW] ? CostMax : s[CostW-1:0];
    endfunction

endpackage

### rtl/core/obst_dp.sv
// ----------------------------------------------------------------------------
// obst_dp: table fill sequencer
// Fills weight, cost and root tables, trying candidate roots in turn with a
// single saturating adder and comparer; reads out roots and the total cost.
// ----------------------------------------------------------------------------
module obst_dp import obst_pkg::*; #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [5:0]           i_n,
    input  logic                 i_q_we,
    input  logic [5:0]           i_q_addr,
    input  logic [15:0]          i_q_data,
    input  logic                 i_p_we,
    input  logic [5:0]           i_p_addr,
    input  logic [15:0]          i_p_data,
    input  logic [5:0]           i_rd_i,
    input  logic [5:0]           i_rd_j,
    output logic [5:0]           o_rd_root,
    output logic [CostW-1:0]     o_total,
    output logic                 o_done
);
    localparam int unsigned Dim   = MAX_KEYS + 1;
    localparam int unsigned Depth = Dim * Dim;
    localparam int unsigned AW    = $clog2(Depth);
    localparam int unsigned QW    = $clog2(Dim);
    localparam int unsigned PW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0, S_DIAG = 3'd1, S_W = 3'd2,
                           S_RD = 3'd3, S_K = 3'd4, S_WR = 3'd5, S_TOT = 3'd6;

    logic [15:0]      mem_q [Dim];
    logic [15:0]      mem_p [MAX_KEYS];
    logic [WgtW-1:0]  mem_w [Depth];
    logic [CostW-1:0] mem_c [Depth];
    logic [5:0]       mem_r [Depth];

    logic [2:0]       r_state;
    logic [5:0]       r_i, r_m, r_k;
    logic [CostW-1:0] r_best, r_ca, r_cb;
    logic [5:0]       r_pick;
    logic [WgtW-1:0]  r_w;
    logic [WgtW-1:0]  r_wprev;
    logic [CostW-1:0] r_total;
    logic             r_done;
    logic [5:0]       r_root_rd;

    logic [5:0]       j_idx;
    logic [CostW-1:0] s_cand;

    function automatic logic [AW-1:0] adr(input logic [5:0] a, input logic [5:0] b);
        return AW'(a * Dim + b);
    endfunction

    assign j_idx  = r_i + r_m;
    assign s_cand = sat_add(r_ca, r_cb);

    // w[i][j-1] is read registered during S_W/S_RD; new w is formed in S_K.
    always_ff @(posedge i_clk) begin
        if (i_q_we) begin
            mem_q[i_q_addr[QW-1:0]] <= i_q_data;
        end
        if (i_p_we) begin
            mem_p[i_p_addr[PW-1:0]] <= i_p_data;
        end
        r_root_rd <= mem_r[adr(i_rd_i, i_rd_j)];
        r_ca <= mem_c[adr(r_i, r_k - 6'd1)];
        r_cb <= mem_c[adr(r_k, j_idx)];
        r_wprev <= mem_w[adr(r_i, j_idx - 6'd1)];
        if (r_state == S_DIAG) begin
            mem_w[adr(r_i, r_i)] <= {6'd0, mem_q[r_i[QW-1:0]]};
            mem_c[adr(r_i, r_i)] <= '0;
            mem_r[adr(r_i, r_i)] <= '0;
        end
        if (r_state == S_K) begin
            r_w <= r_wprev
                   + {6'd0, mem_p[PW'(j_idx - 6'd1)]}
                   + {6'd0, mem_q[j_idx[QW-1:0]]};
        end
        if (r_state == S_WR) begin
            mem_w[adr(r_i, j_idx)] <= r_w;
            mem_c[adr(r_i, j_idx)] <= sat_add({10'd0, r_w}, r_best);
            mem_r[adr(r_i, j_idx)] <= r_pick;
            // whole-range entry is the last one written
            if (r_i == '0 && j_idx == i_n) begin
                r_total <= sat_add({10'd0, r_w}, r_best);
            end
        end
    end

    // best tracks the minimum sum; the final cost adds w once in S_WR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_i <= '0;
                        r_state <= S_DIAG;
                    end
                end
                S_DIAG: begin
                    if (r_i == i_n) begin
                        r_m <= 6'd1;
                        r_i <= '0;
                        r_state <= S_W;
                    end else begin
                        r_i <= r_i + 6'd1;
                    end
                end
                S_W: begin
                    r_k    <= r_i + 6'd1;
                    r_best <= CostMax;
                    r_pick <= r_i + 6'd1;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_k <= r_k + 6'd1;
                    r_state <= S_K;
                end
                S_K: begin
                    // r_ca/r_cb hold the two subtree costs for root r_k-1
                    if (s_cand < r_best) begin
                        r_best <= s_cand;
                        r_pick <= r_k - 6'd1;
                    end
                    if (r_k - 6'd1 == j_idx) begin
                        r_state <= S_WR;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_WR: begin
                    if (j_idx == i_n) begin
                        if (r_m == i_n) begin
                            r_state <= S_TOT;
                        end else begin
                            r_m <= r_m + 6'd1;
                            r_i <= '0;
                            r_state <= S_W;
                        end
                    end else begin
                        r_i <= r_i + 6'd1;
                        r_state <= S_W;
                    end
                end
                S_TOT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rd_root = r_root_rd;
    assign o_total   = r_total;
    assign o_done    = r_done;

    a_done_from_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_TOT) else $error("done without fill");
    a_idle_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_go) |=> r_state == S_DIAG) else $error("go lost");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_K |-> r_k - 6'd1 <= j_idx) else $error("root past range");
endmodule

### rtl/core/obst_walk.sv
// ----------------------------------------------------------------------------
// obst_walk: root table walk
// Depth-first walk with a small stack; one root lookup per node, records
// parent, side and depth per key.
// ----------------------------------------------------------------------------
module obst_walk import obst_pkg::*; #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [5:0]  i_n,
    output logic [5:0]  o_rd_i,
    output logic [5:0]  o_rd_j,
    input  logic [5:0]  i_rd_root,
    input  logic [5:0]  i_key,
    output logic [5:0]  o_par,
    output logic        o_side,
    output logic [5:0]  o_depth,
    output logic        o_done
);
    localparam int unsigned SPW  = $clog2(MAX_KEYS + 1);
    localparam int unsigned StkW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam logic [1:0] S_IDLE = 2'd0, S_POP = 2'd1, S_LK = 2'd2, S_NODE = 2'd3;

    typedef struct packed {
        logic [5:0] i;
        logic [5:0] j;
        logic [5:0] par;
        logic       side;
        logic [5:0] d;
    } t_frame;

    t_frame     r_stack [MAX_KEYS];
    logic [5:0] r_par   [MAX_KEYS+1];
    logic       r_side  [MAX_KEYS+1];
    logic [5:0] r_dep   [MAX_KEYS+1];

    logic [1:0]     r_state;
    logic [SPW-1:0] r_sp;
    t_frame         r_cur;
    logic           r_done;
    logic [5:0]     k;
    logic [SPW-1:0] sp1;

    assign k = i_rd_root;
    always_comb begin
        sp1 = r_sp;
        if (k < r_cur.j && r_sp < SPW'(MAX_KEYS)) begin
            sp1 = r_sp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_sp    <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_go) begin
                        r_stack[0] <= '{i: 6'd0, j: i_n, par: 6'd0, side: 1'b0, d: 6'd0};
                        r_sp <= SPW'(1);
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cur <= r_stack[StkW'(r_sp - 1'b1)];
                        r_sp  <= r_sp - 1'b1;
                        r_state <= S_LK;
                    end
                end
                S_LK: begin
                    if (r_cur.i >= r_cur.j || r_cur.j > i_n) begin
                        r_state <= S_POP;
                    end else begin
                        r_state <= S_NODE;
                    end
                end
                S_NODE: begin
                    if (k > r_cur.i && k <= r_cur.j) begin
                        r_par[k[SPW-1:0]]  <= r_cur.par;
                        r_side[k[SPW-1:0]] <= r_cur.side;
                        r_dep[k[SPW-1:0]]  <= r_cur.d;
                        if (k < r_cur.j && r_sp < SPW'(MAX_KEYS)) begin
                            r_stack[r_sp[StkW-1:0]] <= '{i: k, j: r_cur.j, par: k,
                                                         side: 1'b1, d: r_cur.d + 6'd1};
                        end
                        if (k - 6'd1 > r_cur.i && sp1 < SPW'(MAX_KEYS)) begin
                            r_stack[sp1[StkW-1:0]] <= '{i: r_cur.i, j: k - 6'd1, par: k,
                                                        side: 1'b0, d: r_cur.d + 6'd1};
                            r_sp <= sp1 + 1'b1;
                        end else begin
                            r_sp <= sp1;
                        end
                    end
                    r_state <= S_POP;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rd_i  = r_cur.i;
    assign o_rd_j  = r_cur.j;
    assign o_par   = r_par[i_key[SPW-1:0]];
    assign o_side  = r_side[i_key[SPW-1:0]];
    assign o_depth = r_dep[i_key[SPW-1:0]];
    assign o_done  = r_done;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(MAX_KEYS)) else $error("stack overflow");
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_sp == '0) else $error("done with frames left");
    a_go_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_go) |=> r_sp == SPW'(1)) else $error("no root frame");
endmodule

### rtl/core/optimal_bst_builder.sv
// ----------------------------------------------------------------------------
// optimal_bst_builder: optimal binary search tree builder
// Loads n+1 weight beats, solves the optimal BST tables, emits one result
// beat per key.
// ----------------------------------------------------------------------------
// Usage: write i_cfg_we/i_cfg_data with the key count n (0 acts as 1, above
// MAX_KEYS acts as MAX_KEYS); any write restarts the load. Pulse start with
// a beat on i_item when busy is low. A beat is taken whenever start is high
// while busy is low. The final beat starts the table fill: the diagonal
// entries, then each candidate root in turn (one shared saturating adder and
// compare, cost table read each cycle), then a walk of the root table,
// then n result beats on consecutive cycles with o_valid high. busy goes
// high after the final beat and falls in the cycle that carries the last
// result beat. The receiver cannot stall: every result beat must be taken on
// the cycle it appears.
module optimal_bst_builder import obst_pkg::*; #(
    parameter int unsigned MAX_KEYS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  t_item           i_item,
    input  logic            i_cfg_we,
    input  logic [CfgW-1:0] i_cfg_data,
    output logic            o_valid,
    output t_result         o_result
);
    localparam logic [1:0] S_LOAD = 2'd0, S_FILL = 2'd1, S_WALK = 2'd2, S_OUT = 2'd3;
    localparam int unsigned LblW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    logic [1:0]       r_state;
    logic [CfgW-1:0]  r_num_keys;
    logic [5:0]       r_load;
    logic [5:0]       r_key;
    logic [7:0]       r_labels [MAX_KEYS];
    logic             r_valid;
    t_result          r_res;

    logic [5:0]       n_eff;
    logic             accept, final_beat;
    logic [5:0]       t_idx;
    logic             dp_done, walk_done;
    logic [5:0]       rd_i, rd_j, rd_root, w_par, w_dep;
    logic             w_side;
    logic [CostW-1:0] total;

    always_comb begin
        if (r_num_keys == '0) begin
            n_eff = 6'd1;
        end else if ({1'b0, r_num_keys} > 6'(MAX_KEYS)) begin
            n_eff = 6'(MAX_KEYS);
        end else begin
            n_eff = {1'b0, r_num_keys};
        end
    end

    assign busy       = (r_state != S_LOAD);
    assign accept     = start && !busy;
    assign t_idx      = (r_load > n_eff) ? 6'd0 : r_load;
    assign final_beat = accept && (t_idx == n_eff);

    obst_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .i_clk, .i_rst_n,
        .i_go     (final_beat),
        .i_n      (n_eff),
        .i_q_we   (accept),
        .i_q_addr (t_idx),
        .i_q_data (i_item.miss_weight),
        .i_p_we   (accept && !final_beat),
        .i_p_addr (t_idx),
        .i_p_data (i_item.key_weight),
        .i_rd_i   (rd_i),
        .i_rd_j   (rd_j),
        .o_rd_root(rd_root),
        .o_total  (total),
        .o_done   (dp_done)
    );

    obst_walk #(.MAX_KEYS(MAX_KEYS)) u_walk (
        .i_clk, .i_rst_n,
        .i_go     (dp_done),
        .i_n      (n_eff),
        .o_rd_i   (rd_i),
        .o_rd_j   (rd_j),
        .i_rd_root(rd_root),
        .i_key    (r_key),
        .o_par    (w_par),
        .o_side   (w_side),
        .o_depth  (w_dep),
        .o_done   (walk_done)
    );

    always_ff @(posedge i_clk) begin
        if (accept && !final_beat) begin
            r_labels[t_idx[LblW-1:0]] <= i_item.key_label;
        end
        r_res.key_index      <= r_key[4:0];
        r_res.key_label_out  <= r_labels[LblW'(r_key - 6'd1)];
        r_res.parent_index   <= w_par[4:0];
        r_res.is_right_child <= w_side;
        r_res.node_depth     <= w_dep[3:0];
        r_res.total_cost     <= total;
        r_res.last           <= (r_key == n_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_num_keys <= CfgW'(1);
            r_load     <= '0;
            r_valid    <= 1'b0;
            r_key      <= 6'd1;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_num_keys <= i_cfg_data;
                r_load     <= '0;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept && !i_cfg_we) begin
                        r_load <= final_beat ? 6'd0 : t_idx + 6'd1;
                    end
                    if (final_beat) begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    if (dp_done) begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (walk_done) begin
                        r_key   <= 6'd1;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_valid <= 1'b1;
                    if (r_key == n_eff) begin
                        r_state <= S_LOAD;
                    end else begin
                        r_key <= r_key + 6'd1;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    a_no_valid_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> !o_valid) else $error("result during fill");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |-> r_state == S_LOAD) else $error("last not final");
    a_busy_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        final_beat |=> busy) else $error("busy dropped");
endmodule

### test/tb_optimal_bst_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_optimal_bst_builder: self-checking bench for the optimal BST builder
// Loads weight sets at several key counts, predicts the optimal tree with an
// internal dynamic-programming solver and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_optimal_bst_builder;
    import obst_pkg::*;

    localparam int MaxKeys = 16;
    localparam logic [31:0] AllOnes = 32'hFFFF_FFFF;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    t_item           i_item;
    logic            i_cfg_we;
    logic [CfgW-1:0] i_cfg_data;
    logic            o_valid;
    t_result         o_result;

    optimal_bst_builder #(.MAX_KEYS(MaxKeys)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // ---- tree solver state --------------------------------------------------
    logic [4:0]  key_count;          // raw register value
    int          load_pos;
    logic [15:0] miss_w [0:MaxKeys];
    logic [15:0] hit_w  [0:MaxKeys-1];
    logic [7:0]  label_w[0:MaxKeys-1];
    t_result     tree_q [$];         // expected result beats, oldest first
    int          mismatches;

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? AllOnes : s[31:0];
    endfunction

    function automatic int active_keys();
        if (key_count == 0) return 1;
        if (key_count > MaxKeys) return MaxKeys;
        return int'(key_count);
    endfunction

    // Solve the tables for n keys, walk the tree, queue n result beats.
    task automatic solve_tree(int n);
        logic [21:0] wt  [0:MaxKeys][0:MaxKeys];
        logic [31:0] ct  [0:MaxKeys][0:MaxKeys];
        int          rt  [0:MaxKeys][0:MaxKeys];
        int          par [1:MaxKeys];
        int          side[1:MaxKeys];
        int          dep [1:MaxKeys];
        int          stk_i[$], stk_j[$], stk_p[$], stk_s[$], stk_d[$];
        int          lo, hi, k, p, s, d, pick, j;
        logic [31:0] best, sum;
        t_result     r;
        for (int i = 0; i <= n; i++) begin
            wt[i][i] = 22'(miss_w[i]);
            ct[i][i] = '0;
            rt[i][i] = 0;
        end
        for (int m = 1; m <= n; m++) begin
            for (int i = 0; i + m <= n; i++) begin
                j = i + m;
                best = AllOnes;
                pick = i + 1;
                wt[i][j] = wt[i][j-1] + 22'(hit_w[j-1]) + 22'(miss_w[j]);
                for (int c = i + 1; c <= j; c++) begin
                    sum = add_sat(ct[i][c-1], ct[c][j]);
                    if (sum < best) begin
                        best = sum;
                        pick = c;
                    end
                end
                ct[i][j] = add_sat(32'(wt[i][j]), add_sat(ct[i][pick-1], ct[pick][j]));
                rt[i][j] = pick;
            end
        end
        for (int i = 1; i <= n; i++) begin
            par[i] = 0; side[i] = 0; dep[i] = 0;
        end
        // depth-first walk; right subtree pushed first so left pops first
        stk_i.push_back(0); stk_j.push_back(n); stk_p.push_back(0);
        stk_s.push_back(0); stk_d.push_back(0);
        while (stk_i.size() > 0) begin
            lo = stk_i.pop_back(); hi = stk_j.pop_back(); p = stk_p.pop_back();
            s = stk_s.pop_back(); d = stk_d.pop_back();
            if (lo >= hi) continue;
            k = rt[lo][hi];
            par[k] = p; side[k] = s; dep[k] = d;
            if (k < hi && stk_i.size() < MaxKeys) begin
                stk_i.push_back(k); stk_j.push_back(hi); stk_p.push_back(k);
                stk_s.push_back(1); stk_d.push_back(d + 1);
            end
            if (k - 1 > lo && stk_i.size() < MaxKeys) begin
                stk_i.push_back(lo); stk_j.push_back(k - 1); stk_p.push_back(k);
                stk_s.push_back(0); stk_d.push_back(d + 1);
            end
        end
        for (int i = 1; i <= n; i++) begin
            r.key_index      = 5'(i);
            r.key_label_out  = label_w[i-1];
            r.parent_index   = 5'(par[i]);
            r.is_right_child = side[i][0];
            r.node_depth     = 4'(dep[i]);
            r.total_cost     = ct[0][n];
            r.last           = (i == n);
            tree_q.push_back(r);
        end
    endtask

    // Record one accepted item beat; the final one of a set triggers the solve.
    task automatic take_item(t_item it);
        int n;
        n = active_keys();
        if (load_pos > n) load_pos = 0;
        miss_w[load_pos] = it.miss_weight;
        if (load_pos < n) begin
            hit_w[load_pos]   = it.key_weight;
            label_w[load_pos] = it.key_label;
            load_pos++;
        end else begin
            load_pos = 0;
            solve_tree(n);
        end
    endtask

    // ---- result checker -----------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (tree_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat key %0d", o_result.key_index);
            end else if (o_result !== tree_q[0]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", tree_q[0], o_result);
                void'(tree_q.pop_front());
            end else begin
                void'(tree_q.pop_front());
            end
        end
    end

    // ---- stimulus -----------------------------------------------------------
    int burst_left;

    task automatic send_item(t_item it);
        int gap;
        // sender pacing: random bursts and gaps
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 8);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        take_item(it);
        burst_left--;
        // keep start asserted into the next call; lowered there if needed
    endtask

    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (tree_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_keys(logic [4:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        key_count = v;
        load_pos  = 0;
    endtask

    function automatic t_item rand_item(int mode);
        t_item it;
        it.key_label = 8'($urandom);
        case (mode)
            0: begin
                it.miss_weight = 16'($urandom_range(0, 20));
                it.key_weight  = 16'($urandom_range(0, 20));
            end
            1: begin
                it.miss_weight = 16'hFFFF - 16'($urandom_range(0, 3));
                it.key_weight  = 16'hFFFF - 16'($urandom_range(0, 3));
            end
            default: begin
                it.miss_weight = 16'($urandom);
                it.key_weight  = 16'($urandom);
            end
        endcase
        return it;
    endfunction

    // directed table: key count, then item fields (n+1 beats per set)
    typedef struct {
        logic [4:0] keys;
        logic [15:0] q;
        logic [15:0] p;
        logic [7:0] lbl;
    } t_row;

    t_row dir_tab[] = '{
        // single key at reset count
        '{5'd1, 16'd0,     16'd0,     8'h00},
        '{5'd1, 16'd0,     16'd0,     8'hFF},
        // count zero acts as one
        '{5'd0, 16'hFFFF,  16'hFFFF,  8'hFF},
        '{5'd0, 16'hFFFF,  16'h0000,  8'h00},
        // three keys, all weights maximal
        '{5'd3, 16'hFFFF,  16'hFFFF,  8'hA5},
        '{5'd3, 16'hFFFF,  16'hFFFF,  8'h5A},
        '{5'd3, 16'hFFFF,  16'hFFFF,  8'h01},
        '{5'd3, 16'hFFFF,  16'hFFFF,  8'h80},
        // three keys, all ties: smallest root wins
        '{5'd3, 16'd0,     16'd0,     8'h11},
        '{5'd3, 16'd0,     16'd0,     8'h22},
        '{5'd3, 16'd0,     16'd0,     8'h33},
        '{5'd3, 16'd0,     16'd0,     8'h44},
        // two keys, skewed weights
        '{5'd2, 16'd1,     16'd100,   8'h10},
        '{5'd2, 16'd1,     16'd1,     8'h20},
        '{5'd2, 16'd1,     16'd0,     8'h30}
    };

    initial begin
        t_item it;
        int    n, sets, mode;
        logic [4:0] prev_keys;
        mismatches = 0;
        key_count  = 5'd1;
        load_pos   = 0;
        burst_left = 0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count of 1: the first set goes without a write
        prev_keys = 5'd1;
        foreach (dir_tab[r]) begin
            if (dir_tab[r].keys != prev_keys) begin
                drain();
                write_keys(dir_tab[r].keys);
                prev_keys = dir_tab[r].keys;
            end
            it.miss_weight = dir_tab[r].q;
            it.key_weight  = dir_tab[r].p;
            it.key_label   = dir_tab[r].lbl;
            send_item(it);
        end
        drain();

        // a write mid-load restarts it
        write_keys(5'd4);
        send_item(rand_item(2));
        send_item(rand_item(2));
        drain();
        write_keys(5'd31);              // above max acts as max
        for (int b = 0; b <= MaxKeys; b++) send_item(rand_item(2));
        drain();
        write_keys(5'd16);
        for (int b = 0; b <= MaxKeys; b++) send_item(rand_item(1));
        drain();

        // random sets, 22 of them, mostly small counts
        sets = 0;
        while (sets < 22) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
            write_keys(5'(n));
            n = active_keys();
            mode = $urandom_range(0, 2);
            for (int b = 0; b <= n; b++) send_item(rand_item(mode));
            // occasional broken set: rewrite, then a partial load
            if ($urandom_range(0, 7) == 0) begin
                drain();
                write_keys(5'(n));
                send_item(rand_item(2));
            end
            drain();
            sets++;
        end

        drain();
        if (mismatches == 0 && tree_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### optimal_bst_builder.f
rtl/core/obst_pkg.sv
rtl/core/obst_dp.sv
rtl/core/obst_walk.sv
rtl/core/optimal_bst_builder.sv
test/tb_optimal_bst_builder.sv
